>>> design/clt_pkg.sv
// Shared types, codes and default sizes for the compacting list table.
package clt_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VALUE_WIDTH_DEFAULT = 32;

  // Width that holds any position or depth the table can be built with.
  localparam int POS_EXT_W = 9;

  typedef enum logic [2:0] {
    REQ_REMOVE  = 3'd0,
    REQ_APPEND  = 3'd1,
    REQ_PUT     = 3'd2,
    REQ_WRITE   = 3'd3,
    REQ_REPLACE = 3'd4,
    REQ_READ    = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD       = 2'd3
  } status_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic load;
  } cmd_t;

endpackage

>>> design/clt_ctrl.sv
// Sequencing of request, table update and result beat for the list table.
module clt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output clt_pkg::cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_READY,
    S_EXEC,
    S_POST
  } state_t;

  state_t state;
  logic   out_free;
  logic   in_accept;

  assign out_free  = !out_valid || !out_stall;
  // In the final state a new request may enter in the same cycle as the result loads.
  assign in_stall  = !((state == S_READY) || ((state == S_POST) && out_free));
  assign in_accept = in_valid && !in_stall;

  assign cmd.latch = in_accept;
  assign cmd.exec  = (state == S_EXEC);
  assign cmd.load  = (state == S_POST) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_READY;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_READY: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_POST;
        end
        S_POST: begin
          if (out_free) begin
            state <= in_valid ? S_EXEC : S_READY;
          end
        end
        default: begin
          state <= S_READY;
        end
      endcase

      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> design/clt_datapath.sv
// Entry cells, parallel match and shift logic, and result registers of the list table.
module clt_datapath #(
  parameter int DEPTH       = clt_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = clt_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  clt_pkg::cmd_t cmd,
  input  logic [2:0]    req_type,
  input  logic [31:0]   value,
  input  logic [3:0]    position,
  input  logic [31:0]   new_value,
  output logic [1:0]    status,
  output logic [31:0]   read_value,
  output logic [4:0]    first_empty
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int ZW    = $clog2(DEPTH + 1);
  localparam int PW    = clt_pkg::POS_EXT_W;

  typedef logic [VALUE_WIDTH-1:0] word_t;

  word_t                entry [DEPTH];
  word_t                entry_next [DEPTH];
  word_t                shifted [DEPTH];

  clt_pkg::req_t        req_q;
  word_t                val_q;
  word_t                nval_q;
  logic [3:0]           pos_q;
  clt_pkg::status_t     status_q;
  clt_pkg::status_t     status_next;

  logic [DEPTH-1:0]     empty_vec;
  logic [DEPTH-1:0]     empty_first;
  logic [DEPTH-1:0]     below_z;
  logic [DEPTH-1:0]     match_vec;
  logic [DEPTH-1:0]     match_first;
  logic [DEPTH-1:0]     rm_first;
  logic [DEPTH-1:0]     shift_mask;
  logic [DEPTH-1:0]     pos_sel;
  logic                 empty_any;
  logic                 rm_any;
  logic                 match_any;
  logic [ZW-1:0]        z;
  logic [IDX_W-1:0]     pos_idx;
  logic                 pos_ok;
  word_t                rd_entry;
  logic [63:0]          value_ext;
  logic [63:0]          new_value_ext;
  logic [63:0]          rd_ext;
  logic [PW-1:0]        z_ext;

  function automatic logic [DEPTH-1:0] lowest_one(input logic [DEPTH-1:0] v);
    return v & (~v + DEPTH'(1));
  endfunction

  function automatic logic [IDX_W-1:0] encode(input logic [DEPTH-1:0] onehot);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (onehot[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
    return idx;
  endfunction

  assign value_ext     = 64'(value);
  assign new_value_ext = 64'(new_value);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q  <= clt_pkg::req_t'(req_type);
      val_q  <= value_ext[VALUE_WIDTH-1:0];
      nval_q <= new_value_ext[VALUE_WIDTH-1:0];
      pos_q  <= position;
    end
  end

  // Per-cell compares; the first empty and first match come from isolating the lowest set bit.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      empty_vec[i] = (entry[i] == '0);
      match_vec[i] = (entry[i] == val_q);
    end
  end

  assign empty_first = lowest_one(empty_vec);
  assign empty_any   = |empty_vec;
  // With no empty slot the subtraction wraps to all ones, which is the whole table.
  assign below_z     = empty_first - DEPTH'(1);
  assign z           = empty_any ? ZW'(encode(empty_first)) : ZW'(DEPTH);

  assign match_first = lowest_one(match_vec);
  assign match_any   = |match_vec;
  assign rm_first    = lowest_one(match_vec & below_z);
  assign rm_any      = |(match_vec & below_z);
  assign shift_mask  = ~(rm_first - DEPTH'(1)) & below_z;

  assign pos_idx  = PW'(pos_q) < PW'(DEPTH) ? IDX_W'(pos_q) : '0;
  assign pos_ok   = PW'(pos_q) < PW'(DEPTH);
  assign rd_entry = pos_ok ? entry[pos_idx] : '0;

  always_comb begin
    pos_sel = '0;
    if (pos_ok) begin
      pos_sel[pos_idx] = 1'b1;
    end
  end

  // On a remove, cells from the match to the first empty shift down; the top cell takes zero.
  always_comb begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      shifted[i] = entry[i + 1];
    end
    shifted[DEPTH-1] = '0;
  end

  always_comb begin
    status_next = clt_pkg::ST_OK;
    for (int i = 0; i < DEPTH; i++) begin
      entry_next[i] = entry[i];
    end
    case (req_q)
      clt_pkg::REQ_REMOVE: begin
        if (rm_any) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (shift_mask[i]) begin
              entry_next[i] = shifted[i];
            end
          end
        end else begin
          status_next = clt_pkg::ST_NOT_FOUND;
        end
      end
      clt_pkg::REQ_APPEND: begin
        if (empty_any) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (empty_first[i]) begin
              entry_next[i] = val_q;
            end
          end
        end else begin
          status_next = clt_pkg::ST_FULL;
        end
      end
      clt_pkg::REQ_PUT: begin
        if (pos_ok && (rd_entry == '0)) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (pos_sel[i]) begin
              entry_next[i] = val_q;
            end
          end
        end else begin
          status_next = clt_pkg::ST_BAD;
        end
      end
      clt_pkg::REQ_WRITE: begin
        if (pos_ok) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (pos_sel[i]) begin
              entry_next[i] = nval_q;
            end
          end
        end else begin
          status_next = clt_pkg::ST_BAD;
        end
      end
      clt_pkg::REQ_REPLACE: begin
        if (match_any) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (match_first[i]) begin
              entry_next[i] = nval_q;
            end
          end
        end else begin
          status_next = clt_pkg::ST_NOT_FOUND;
        end
      end
      clt_pkg::REQ_READ: begin
        if (!pos_ok) begin
          status_next = clt_pkg::ST_BAD;
        end
      end
      default: begin
        status_next = clt_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        entry[i] <= '0;
      end
    end else if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        entry[i] <= entry_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_q <= status_next;
    end
  end

  // The result is read from the updated table when the result register loads.
  assign rd_ext = 64'(rd_entry);
  assign z_ext  = PW'(z);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status      <= status_q;
      read_value  <= rd_ext[31:0];
      first_empty <= z_ext[4:0];
    end
  end

endmodule

>>> design/compacting_list_table_top.sv
// Top level of the compacting list table: controller and datapath.
//
//   channel   handshake              beat contents
//   input     in_valid / in_stall    req_type, value, position, new_value
//   output    out_valid / out_stall  status, read_value, first_empty
//
// Each request is latched, then updates the entry cells through the
// parallel compare and shift logic, then loads the result register from the
// updated table. A new request enters in the cycle its predecessor's result
// loads. Synchronous reset empties every cell at once. A stalled result beat
// holds the next request back in its final cycle.
module compacting_list_table_top #(
  parameter int DEPTH       = clt_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = clt_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [31:0] value,
  input  logic [3:0]  position,
  input  logic [31:0] new_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] read_value,
  output logic [4:0]  first_empty
);

  clt_pkg::cmd_t cmd;

  clt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  clt_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req_type    (req_type),
    .value       (value),
    .position    (position),
    .new_value   (new_value),
    .status      (status),
    .read_value  (read_value),
    .first_empty (first_empty)
  );

endmodule

>>> design/clt_checker.sv
// Port-level checks for the compacting list table, bound to the top level.
module clt_checker #(
  parameter int DEPTH = clt_pkg::DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [31:0] read_value,
  input logic [4:0]  first_empty
);

  localparam logic [4:0] FULL_Z = 5'(DEPTH);

  // A held result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(read_value)
      && $stable(first_empty))
    else $error("result beat changed while stalled");

  // The table is busy for the cycle after a request beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted during update cycle");

  // Every request beat yields a result beat.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> ##3 out_valid)
    else $error("no result after request");

  // A refused append leaves the table full.
  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == clt_pkg::ST_FULL) |-> first_empty == FULL_Z)
    else $error("full status with a free slot");

endmodule

bind compacting_list_table_top clt_checker #(
  .DEPTH (DEPTH)
) u_clt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .read_value  (read_value),
  .first_empty (first_empty)
);

>>> tb/compacting_list_table_top_test.sv
// Self-checking testbench for the compacting list table: directed rows, then random requests.
`timescale 1ns / 1ps

module compacting_list_table_top_test;

  localparam int TABLE_DEPTH = clt_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 1200;
  localparam int QUIET_LIMIT = 2000;

  // Request codes that the block treats as no-ops.
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  typedef struct packed {
    clt_pkg::status_t status;
    logic [31:0]      read_value;
    logic [4:0]       first_empty;
  } table_result_t;

  typedef struct {
    logic [2:0]    kind;
    logic [31:0]   key;
    logic [3:0]    slot;
    logic [31:0]   fresh;
    bit            typed;
    table_result_t want;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  req_type = '0;
  logic [31:0] value = '0;
  logic [3:0]  position = '0;
  logic [31:0] new_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] read_value;
  logic [4:0]  first_empty;

  logic [31:0]   shadow_table [TABLE_DEPTH];
  logic [31:0]   fill_words [TABLE_DEPTH];
  table_result_t pending_results [$];
  table_row_t    directed_rows [$];
  int            idle_pct = 16;
  int            failures = 0;
  int            quiet_cycles = 0;

  compacting_list_table_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .value(value), .position(position), .new_value(new_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .read_value(read_value), .first_empty(first_empty)
  );

  always #2 clk = ~clk;

  function automatic int lowest_empty();
    int z;
    z = TABLE_DEPTH;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (shadow_table[i] == '0) z = i;
    end
    return z;
  endfunction

  // Applies one request to the shadow copy and returns the beat it should produce.
  function automatic table_result_t apply_request(input logic [2:0] kind,
      input logic [31:0] key, input logic [3:0] slot, input logic [31:0] fresh);
    table_result_t res;
    int z;
    int hit;
    z = lowest_empty();
    hit = z;
    res.status = clt_pkg::ST_OK;
    case (kind)
      clt_pkg::REQ_REMOVE: begin
        // Only the packed run below the first empty slot is searched.
        for (int i = 0; i < z && hit == z; i++) begin
          if (shadow_table[i] == key) hit = i;
        end
        if (hit == z) begin
          res.status = clt_pkg::ST_NOT_FOUND;
        end else begin
          for (int i = hit; i + 1 < z; i++) shadow_table[i] = shadow_table[i + 1];
          shadow_table[z - 1] = '0;
        end
      end
      clt_pkg::REQ_APPEND: begin
        if (z >= TABLE_DEPTH) res.status = clt_pkg::ST_FULL;
        else shadow_table[z] = key;
      end
      clt_pkg::REQ_PUT: begin
        if (slot >= TABLE_DEPTH || shadow_table[slot] != '0) res.status = clt_pkg::ST_BAD;
        else shadow_table[slot] = key;
      end
      clt_pkg::REQ_WRITE: begin
        if (slot >= TABLE_DEPTH) res.status = clt_pkg::ST_BAD;
        else shadow_table[slot] = fresh;
      end
      clt_pkg::REQ_REPLACE: begin
        hit = TABLE_DEPTH;
        for (int i = 0; i < TABLE_DEPTH && hit == TABLE_DEPTH; i++) begin
          if (shadow_table[i] == key) hit = i;
        end
        if (hit == TABLE_DEPTH) res.status = clt_pkg::ST_NOT_FOUND;
        else shadow_table[hit] = fresh;
      end
      clt_pkg::REQ_READ: begin
        if (slot >= TABLE_DEPTH) res.status = clt_pkg::ST_BAD;
      end
      default: ;
    endcase
    res.read_value = (slot < TABLE_DEPTH) ? shadow_table[slot] : '0;
    res.first_empty = 5'(lowest_empty());
    return res;
  endfunction

  function automatic void add_row(input logic [2:0] kind, input logic [31:0] key,
      input logic [3:0] slot, input logic [31:0] fresh, input bit typed,
      input table_result_t want);
    table_row_t row;
    row.kind = kind;
    row.key = key;
    row.slot = slot;
    row.fresh = fresh;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [31:0] pick_word(input bit for_key);
    int r;
    r = $urandom_range(99);
    if (for_key && r < 40) return shadow_table[$urandom_range(TABLE_DEPTH - 1)];
    if (r < 55) return 32'($urandom_range(8, 1));
    if (r < 65) return '0;
    return $urandom;
  endfunction

  // While filling, appends outweigh removals; while draining, the reverse.
  function automatic table_row_t random_request(input bit filling);
    table_row_t row;
    int r;
    int append_cut;
    append_cut = filling ? 40 : 14;
    r = $urandom_range(99);
    if (r < append_cut) row.kind = clt_pkg::REQ_APPEND;
    else if (r < 54) row.kind = clt_pkg::REQ_REMOVE;
    else if (r < 64) row.kind = clt_pkg::REQ_PUT;
    else if (r < 74) row.kind = clt_pkg::REQ_WRITE;
    else if (r < 84) row.kind = clt_pkg::REQ_REPLACE;
    else if (r < 95) row.kind = clt_pkg::REQ_READ;
    else row.kind = $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;
    row.key = pick_word(1'b1);
    row.fresh = pick_word(1'b0);
    row.slot = 4'($urandom_range(TABLE_DEPTH - 1));
    if (row.kind == clt_pkg::REQ_PUT && $urandom_range(1) && lowest_empty() < TABLE_DEPTH) begin
      row.slot = 4'(lowest_empty());
    end
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  task automatic issue(input table_row_t row);
    table_result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= row.kind;
    value <= row.key;
    position <= row.slot;
    new_value <= row.fresh;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_request(row.kind, row.key, row.slot, row.fresh);
    pending_results.push_back(row.typed ? row.want : predicted);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
      input logic [31:0] got);
    failures++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin : result_check
    table_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", '0, {30'd0, status});
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          report_mismatch("status", 32'(want.status), 32'(status));
        end
        if (read_value !== want.read_value) begin
          report_mismatch("read_value", want.read_value, read_value);
        end
        if (first_empty !== want.first_empty) begin
          report_mismatch("first_empty", 32'(want.first_empty), 32'(first_empty));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("compacting_list_table_top regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    foreach (shadow_table[i]) shadow_table[i] = '0;
    foreach (fill_words[i]) begin
      fill_words[i] = (i == 0) ? 32'hFFFF_FFFF : (i == 1) ? 32'h1 :
                      (i == 2) ? 32'h8000_0000 : 32'h0101_0000 * i + i;
    end

    add_row(clt_pkg::REQ_READ, 32'd0, 4'd0, 32'd0, 1'b1,
            table_result_t'{clt_pkg::ST_OK, 32'd0, 5'd0});
    add_row(clt_pkg::REQ_REMOVE, 32'd5, 4'd0, 32'd0, 1'b1,
            table_result_t'{clt_pkg::ST_NOT_FOUND, 32'd0, 5'd0});
    add_row(clt_pkg::REQ_APPEND, 32'd0, 4'd0, 32'd0, 1'b1,
            table_result_t'{clt_pkg::ST_OK, 32'd0, 5'd0});
    // A zero search key lands on the first empty slot.
    add_row(clt_pkg::REQ_REPLACE, 32'd0, 4'd0, 32'h5555_5555, 1'b0, '0);
    add_row(clt_pkg::REQ_REMOVE, 32'h5555_5555, 4'd0, 32'd0, 1'b0, '0);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      add_row(clt_pkg::REQ_WRITE, 32'd0, 4'(i), fill_words[i], 1'b0, '0);
    end
    add_row(clt_pkg::REQ_APPEND, 32'h2468, 4'd15, 32'd0, 1'b1,
            table_result_t'{clt_pkg::ST_FULL, fill_words[15], 5'(TABLE_DEPTH)});
    add_row(clt_pkg::REQ_PUT, 32'd9, 4'd4, 32'd0, 1'b1,
            table_result_t'{clt_pkg::ST_BAD, fill_words[4], 5'(TABLE_DEPTH)});
    add_row(clt_pkg::REQ_REMOVE, fill_words[2], 4'd2, 32'd0, 1'b0, '0);
    add_row(clt_pkg::REQ_WRITE, 32'd0, 4'd6, 32'd0, 1'b0, '0);
    // This entry now sits above the hole, so remove must miss it.
    add_row(clt_pkg::REQ_REMOVE, fill_words[10], 4'd9, 32'd0, 1'b0, '0);
    add_row(clt_pkg::REQ_PUT, 32'hAAAA_AAAA, 4'd6, 32'd0, 1'b0, '0);
    add_row(REQ_SPARE_LO, 32'h7FFF_FFFF, 4'd6, 32'hFFFF_FFFF, 1'b0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) issue(directed_rows[k]);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_pct = (n >= 500 && n < 800) ? 0 : 16;
      issue(random_request((n / 120) % 2 == 0));
    end
    in_valid <= 1'b0;
    idle_pct = 16;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("compacting_list_table_top regression: pass");
    end else begin
      $display("compacting_list_table_top regression: fail");
    end
    $finish;
  end

endmodule

>>> compacting_list_table_top.f
design/clt_pkg.sv
design/clt_ctrl.sv
design/clt_datapath.sv
design/compacting_list_table_top.sv
design/clt_checker.sv
tb/compacting_list_table_top_test.sv
